>>> rtl/bpd_pkg.sv
// Shared types, constants and register codes of the blow pressure detector.
package bpd_pkg;

  // Field widths
  localparam int SAMPLE_W   = 12;
  localparam int TIME_W     = 32;
  localparam int PROGRESS_W = 7;
  localparam int LEVEL_W    = 5;
  localparam int HOLD_W     = 3;
  localparam int THRESH_W   = 12;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_LEVEL = 1'b0;
  localparam logic REG_HOLD  = 1'b1;

  // Defaults for the top-level parameters
  localparam int SAMPLES_PER_MEAN_DEF = 5;
  localparam int QUEUE_DEPTH_DEF      = 2;

  // Detection constants
  localparam logic [SAMPLE_W-1:0]   SAMPLE_LOW     = 12'd800;
  localparam logic [SAMPLE_W-1:0]   SAMPLE_HIGH    = 12'd3900;
  localparam logic [THRESH_W-1:0]   THRESHOLD_BASE = 12'd900;
  localparam logic [THRESH_W-1:0]   THRESHOLD_STEP = 12'd100;
  localparam logic [PROGRESS_W-1:0] FINISH_COUNT   = 7'd100;
  localparam logic [TIME_W-1:0]     HOLD_TIME_MS   = 32'd1500;
  localparam logic [HOLD_W-1:0]     MAX_STEP       = 3'd6;
  localparam logic [HOLD_W-1:0]     HOLD_MAX       = 3'd5;

  // Item class decided by the front end
  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_KEEP,
    KIND_SKIP
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [SAMPLE_W-1:0]  pressure_sample;
    logic [TIME_W-1:0]    time_ms;
  } item_t;

  // Values derived from the configuration registers
  typedef struct packed {
    logic [THRESH_W-1:0] threshold;
    logic [HOLD_W-1:0]   step;
  } cfg_t;

  typedef struct packed {
    logic                  detected;
    logic [PROGRESS_W-1:0] progress;
    logic                  mean_valid;
    logic [SAMPLE_W-1:0]   mean_value;
    logic                  strong_pulse;
  } result_t;

endpackage

>>> rtl/bpd_channels.sv
// Valid/ready channel interfaces for sample and result transactions.
interface bpd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [bpd_pkg::SAMPLE_W-1:0]  pressure_sample;
  logic [bpd_pkg::TIME_W-1:0]    time_ms;

  modport source (output valid, command, pressure_sample, time_ms, input ready);
  modport sink   (input valid, command, pressure_sample, time_ms, output ready);
endinterface

interface bpd_out_if;
  logic                            valid;
  logic                            ready;
  logic                            detected;
  logic [bpd_pkg::PROGRESS_W-1:0]  progress;
  logic                            mean_valid;
  logic [bpd_pkg::SAMPLE_W-1:0]    mean_value;
  logic                            strong_pulse;

  modport source (output valid, detected, progress, mean_valid, mean_value, strong_pulse,
                  input ready);
  modport sink   (input valid, detected, progress, mean_valid, mean_value, strong_pulse,
                  output ready);
  modport mon    (input valid, ready, detected, progress, mean_valid, mean_value,
                  strong_pulse);
endinterface

>>> rtl/bpd_front.sv
// Front end: accept sample transactions, classify them and register the result.
module bpd_front (
  input  logic            clk,
  input  logic            rst,
  bpd_in_if.sink          sample_ch,
  output logic            item_valid,
  input  logic            item_ready,
  output bpd_pkg::item_t  item
);

  bpd_pkg::item_t classified;

  assign sample_ch.ready = !item_valid || item_ready;

  always_comb begin
    classified.pressure_sample = sample_ch.pressure_sample;
    classified.time_ms         = sample_ch.time_ms;
    if (sample_ch.command) begin
      classified.kind = bpd_pkg::KIND_CLEAR;
    end else if (sample_ch.pressure_sample > bpd_pkg::SAMPLE_LOW &&
                 sample_ch.pressure_sample < bpd_pkg::SAMPLE_HIGH) begin
      classified.kind = bpd_pkg::KIND_KEEP;
    end else begin
      classified.kind = bpd_pkg::KIND_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (sample_ch.ready) begin
      item_valid <= sample_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ch.ready && sample_ch.valid) begin
      item <= classified;
    end
  end

endmodule

>>> rtl/bpd_queue.sv
// Short register queue between front end and back end.
module bpd_queue #(
  parameter int DEPTH = bpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  bpd_pkg::item_t  push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output bpd_pkg::item_t  pop_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bpd_pkg::item_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_FULL;
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

>>> rtl/bpd_back.sv
// Back end: block averaging, threshold test, blow count and detection timer.
module bpd_back #(
  parameter int SAMPLES_PER_MEAN = bpd_pkg::SAMPLES_PER_MEAN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bpd_pkg::cfg_t     cfg,
  input  logic              item_valid,
  output logic              item_ready,
  input  bpd_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output bpd_pkg::result_t  result
);

  localparam int LOG_N   = $clog2(SAMPLES_PER_MEAN);
  localparam int SUM_W   = bpd_pkg::SAMPLE_W + LOG_N;
  localparam int SHIFT   = SUM_W + LOG_N;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + SAMPLES_PER_MEAN - 1) / SAMPLES_PER_MEAN;
  localparam int FILL_W  = (SAMPLES_PER_MEAN > 1) ? LOG_N : 1;
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(SAMPLES_PER_MEAN - 1);

  logic [FILL_W-1:0]              fill_index, fill_index_next;
  logic [SUM_W-1:0]               block_sum, block_sum_next;
  logic [bpd_pkg::PROGRESS_W-1:0] blow_count, blow_count_next;
  logic [bpd_pkg::TIME_W-1:0]     start_time, start_time_next;
  logic                           start_marked, start_marked_next;
  logic                           finished, finished_next;

  logic [SUM_W-1:0]               sum_new;
  logic [PROD_W-1:0]              product;
  logic [bpd_pkg::SAMPLE_W-1:0]   mean;
  logic                           above_threshold;
  logic [bpd_pkg::PROGRESS_W-1:0] count_up;
  logic [bpd_pkg::TIME_W-1:0]     elapsed;
  logic                           take;
  bpd_pkg::result_t               res;

  assign item_ready = !result_valid || result_ready;
  assign take       = item_valid && item_ready;

  // Mean by reciprocal multiply: exact for every sum below 2^SUM_W.
  assign sum_new         = block_sum + SUM_W'(item.pressure_sample);
  assign product         = PROD_W'(sum_new) * PROD_W'(RECIP);
  assign mean            = product[SHIFT +: bpd_pkg::SAMPLE_W];
  assign above_threshold = mean > cfg.threshold;
  assign count_up        = blow_count + bpd_pkg::PROGRESS_W'(cfg.step);
  assign elapsed         = item.time_ms - start_time;

  always_comb begin
    fill_index_next   = fill_index;
    block_sum_next    = block_sum;
    blow_count_next   = blow_count;
    start_time_next   = start_time;
    start_marked_next = start_marked;
    finished_next     = finished;
    res               = '0;
    res.progress      = blow_count;

    if (item.kind == bpd_pkg::KIND_CLEAR) begin
      fill_index_next   = '0;
      block_sum_next    = '0;
      blow_count_next   = '0;
      start_time_next   = '0;
      start_marked_next = 1'b0;
      finished_next     = 1'b0;
      res.progress      = '0;
    end else if (finished) begin
      res.detected = elapsed >= bpd_pkg::HOLD_TIME_MS;
    end else if (item.kind == bpd_pkg::KIND_KEEP) begin
      if (fill_index == FILL_LAST) begin
        fill_index_next = '0;
        block_sum_next  = '0;
        res.mean_valid  = 1'b1;
        res.mean_value  = mean;
        res.strong_pulse = above_threshold;
        if (above_threshold) begin
          blow_count_next = count_up;
          if (!start_marked) begin
            start_time_next   = item.time_ms;
            start_marked_next = 1'b1;
          end
        end else begin
          blow_count_next   = '0;
          start_time_next   = '0;
          start_marked_next = 1'b0;
        end
        finished_next = blow_count_next >= bpd_pkg::FINISH_COUNT;
        res.progress  = blow_count_next;
      end else begin
        fill_index_next = fill_index + FILL_W'(1);
        block_sum_next  = sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_index   <= '0;
      block_sum    <= '0;
      blow_count   <= '0;
      start_time   <= '0;
      start_marked <= 1'b0;
      finished     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        fill_index   <= fill_index_next;
        block_sum    <= block_sum_next;
        blow_count   <= blow_count_next;
        start_time   <= start_time_next;
        start_marked <= start_marked_next;
        finished     <= finished_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res;
    end
  end

endmodule

>>> rtl/blow_pressure_detector.sv
// Top level of the blow pressure detector: channels, register port and pipeline.
//
//  channel    dir  handshake      payload
//  sample_ch  in   valid/ready    command, pressure_sample, time_ms
//  result_ch  out  valid/ready    detected, progress, mean_valid, mean_value, strong_pulse
//  apb        in   psel/penable   paddr, pwdata, pwrite -> prdata, pready
//
// One transaction per cycle sustained while neither side stalls; the accepting edge
// loads the front register, then the queue and then the back-end result register,
// from which a result shows on result_ch. The back end updates all detector state
// per item: running sum, reciprocal multiply for the mean, threshold test.
// rst is synchronous and clears control and detector state and both registers.
// Either side may stall on its own: the queue absorbs items while the result waits,
// and sample_ch.ready drops only when the queue is full.
module blow_pressure_detector #(
  parameter int SAMPLES_PER_MEAN = bpd_pkg::SAMPLES_PER_MEAN_DEF,
  parameter int QUEUE_DEPTH      = bpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  bpd_in_if.sink                       sample_ch,
  bpd_out_if.source                    result_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpd_pkg::ADDR_W-1:0]   paddr,
  input  logic [bpd_pkg::DATA_W-1:0]   pwdata,
  output logic [bpd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic [bpd_pkg::LEVEL_W-1:0] pressure_level;
  logic [bpd_pkg::HOLD_W-1:0]  hold_setting;
  logic [bpd_pkg::HOLD_W-1:0]  hold_clamped;
  logic                        reg_write;
  logic                        reg_index;
  bpd_pkg::cfg_t               cfg;

  logic             front_valid;
  logic             front_ready;
  bpd_pkg::item_t   front_item;
  logic             queue_valid;
  logic             queue_ready;
  bpd_pkg::item_t   queue_item;
  bpd_pkg::result_t back_result;

  // Register port: zero wait states, index taken from the word address bit.
  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_level <= '0;
      hold_setting   <= '0;
    end else if (reg_write) begin
      case (reg_index)
        bpd_pkg::REG_LEVEL: pressure_level <= pwdata[bpd_pkg::LEVEL_W-1:0];
        bpd_pkg::REG_HOLD:  hold_setting   <= pwdata[bpd_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      bpd_pkg::REG_LEVEL: prdata = bpd_pkg::DATA_W'(pressure_level);
      bpd_pkg::REG_HOLD:  prdata = bpd_pkg::DATA_W'(hold_setting);
      default:            prdata = '0;
    endcase
  end

  // Threshold and count step depend only on the registers; hold above five acts as five.
  assign hold_clamped  = (hold_setting > bpd_pkg::HOLD_MAX) ? bpd_pkg::HOLD_MAX : hold_setting;
  assign cfg.step      = bpd_pkg::MAX_STEP - hold_clamped;
  assign cfg.threshold = bpd_pkg::THRESHOLD_BASE +
                         bpd_pkg::THRESH_W'(pressure_level) * bpd_pkg::THRESHOLD_STEP;

  bpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample_ch  (sample_ch),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  bpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_item   (queue_item)
  );

  bpd_back #(
    .SAMPLES_PER_MEAN (SAMPLES_PER_MEAN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (queue_valid),
    .item_ready   (queue_ready),
    .item         (queue_item),
    .result_valid (result_ch.valid),
    .result_ready (result_ch.ready),
    .result       (back_result)
  );

  assign result_ch.detected     = back_result.detected;
  assign result_ch.progress     = back_result.progress;
  assign result_ch.mean_valid   = back_result.mean_valid;
  assign result_ch.mean_value   = back_result.mean_value;
  assign result_ch.strong_pulse = back_result.strong_pulse;

endmodule

>>> rtl/bpd_checker.sv
// Port-level checks on result transactions, bound to the top level.
module bpd_checker (
  input  logic       clk,
  input  logic       rst,
  bpd_out_if.source  result_ch
);

  // Hold a stalled result valid and its progress, mean value, detected and mean_valid fields steady.
  assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && !result_ch.ready |=>
      result_ch.valid && $stable(result_ch.progress) && $stable(result_ch.mean_value) &&
      $stable(result_ch.detected) && $stable(result_ch.mean_valid))
    else $error("stalled result changed");

  // Without a mean, mean fields stay zero.
  assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && !result_ch.mean_valid |->
      result_ch.mean_value == '0 && !result_ch.strong_pulse)
    else $error("mean fields set without a mean");

  // A strong pulse comes with a mean and never on a detection tick.
  assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && result_ch.strong_pulse |-> result_ch.mean_valid && !result_ch.detected)
    else $error("strong pulse without mean or during detection");

  // Count never exceeds the last step past the finish mark.
  assert property (@(posedge clk) disable iff (rst)
    result_ch.valid |-> result_ch.progress <= 7'd105)
    else $error("progress out of range");

endmodule

bind blow_pressure_detector bpd_checker u_bpd_checker (
  .clk       (clk),
  .rst       (rst),
  .result_ch (result_ch)
);
